// ----- hdl/bmc_pkg.sv -----
`default_nettype none

package bmc_pkg;

    localparam int unsigned CFG_WIDTH = 16;
    localparam int unsigned CFG_INDEX_WIDTH = 8;
    localparam int unsigned TALLY_WIDTH = 3;

    localparam logic [TALLY_WIDTH-1:0] TALLY_MAX = 3'd7;
    localparam logic [TALLY_WIDTH-1:0] TALLY_ONE = 3'd1;
    localparam logic [TALLY_WIDTH-1:0] TALLY_TRIPLE = 3'd3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_PRESS = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_PRESS = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MULTI_WINDOW = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SINGLE_FAST = 8'd3;

    localparam logic [CFG_WIDTH-1:0] MIN_PRESS_RESET = 16'd50;
    localparam logic [CFG_WIDTH-1:0] MAX_PRESS_RESET = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] MULTI_WINDOW_RESET = 16'd10000;
    localparam logic [CFG_WIDTH-1:0] SINGLE_FAST_RESET = 16'd1000;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_TRIPLE = 2'd2,
        EV_QUINT  = 2'd3
    } t_event;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] min_press_ms;
        logic [CFG_WIDTH-1:0] max_press_ms;
        logic [CFG_WIDTH-1:0] multi_window_ms;
        logic [CFG_WIDTH-1:0] single_fast_ms;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hdl/bmc_cfg.sv -----
`default_nettype none

module bmc_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_wr,
    input  wire logic [bmc_pkg::CFG_INDEX_WIDTH-1:0] i_index,
    input  wire logic [bmc_pkg::CFG_WIDTH-1:0]       i_data,
    output bmc_pkg::t_cfg                            o_cfg
);
    import bmc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                REG_MIN_PRESS:    n_cfg.min_press_ms = i_data;
                REG_MAX_PRESS:    n_cfg.max_press_ms = i_data;
                REG_MULTI_WINDOW: n_cfg.multi_window_ms = i_data;
                REG_SINGLE_FAST:  n_cfg.single_fast_ms = i_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_press_ms <= MIN_PRESS_RESET;
            r_cfg.max_press_ms <= MAX_PRESS_RESET;
            r_cfg.multi_window_ms <= MULTI_WINDOW_RESET;
            r_cfg.single_fast_ms <= SINGLE_FAST_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hdl/bmc_step.sv -----
`default_nettype none

module bmc_step #(
    parameter int unsigned QUINT_CLICKS = 5,
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_fire,
    input  wire logic                            i_pressed,
    input  wire logic [TIME_BITS-1:0]            i_now,
    input  wire bmc_pkg::t_cfg                   i_cfg,
    output bmc_pkg::t_event                      o_event,
    output logic [bmc_pkg::TALLY_WIDTH-1:0]      o_tally
);
    import bmc_pkg::*;

    logic                   r_held;
    logic                   n_held;
    logic [TIME_BITS-1:0]   r_press;
    logic [TIME_BITS-1:0]   n_press;
    logic [TIME_BITS-1:0]   r_burst;
    logic [TIME_BITS-1:0]   n_burst;
    logic [TALLY_WIDTH-1:0] r_tally;
    logic [TALLY_WIDTH-1:0] edge_tally;
    logic [TALLY_WIDTH-1:0] n_tally;
    logic [TIME_BITS-1:0]   dur;
    logic [TIME_BITS-1:0]   win;
    t_event                 ev;

    assign dur = i_now - r_press;
    assign win = i_now - n_burst;

    // press and release edges
    always_comb begin
        n_held = r_held;
        n_press = r_press;
        n_burst = r_burst;
        edge_tally = r_tally;
        priority if (i_pressed && !r_held) begin
            n_held = 1'b1;
            n_press = i_now;
            if (r_tally == '0) begin
                n_burst = i_now;
            end
        end else if (!i_pressed && r_held) begin
            n_held = 1'b0;
            if (dur >= TIME_BITS'(i_cfg.min_press_ms) && dur <= TIME_BITS'(i_cfg.max_press_ms)
                    && r_tally != TALLY_MAX) begin
                edge_tally = r_tally + TALLY_ONE;
            end
        end else begin
            n_held = r_held;
        end
    end

    // window checks
    always_comb begin
        ev = EV_NONE;
        n_tally = edge_tally;
        if (edge_tally != '0) begin
            priority if (edge_tally >= TALLY_WIDTH'(QUINT_CLICKS)
                    && win <= TIME_BITS'(i_cfg.multi_window_ms)) begin
                ev = EV_QUINT;
                n_tally = '0;
            end else if (win > TIME_BITS'(i_cfg.multi_window_ms)) begin
                if (edge_tally == TALLY_TRIPLE) begin
                    ev = EV_TRIPLE;
                end else if (edge_tally == TALLY_ONE) begin
                    ev = EV_SHORT;
                end
                n_tally = '0;
            end else if (edge_tally == TALLY_ONE && win > TIME_BITS'(i_cfg.single_fast_ms)
                    && !n_held) begin
                ev = EV_SHORT;
                n_tally = '0;
            end else begin
                n_tally = edge_tally;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
            r_press <= '0;
            r_burst <= '0;
            r_tally <= '0;
        end else if (i_fire) begin
            r_held <= n_held;
            r_press <= n_press;
            r_burst <= n_burst;
            r_tally <= n_tally;
        end
    end

    assign o_event = ev;
    assign o_tally = n_tally;

endmodule

`default_nettype wire

// ----- hdl/button_multi_click_classifier_top.sv -----
// path: an accepted request is held in the input register, and its result then
// moves into the result register once the result side can advance
// throughput: one request per cycle; input and result registers stall only
// when the result is not taken
// reset: synchronous active-low, clears the pipeline, button state and click
// tally, and loads the default timing registers
`default_nettype none

module button_multi_click_classifier_top #(
    parameter int unsigned QUINT_CLICKS = 5,
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [39:0]                         i_s_tdata,   // pressed, now_ms
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [7:0]                               o_m_tdata,   // event_res, clicks_pending
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bmc_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [bmc_pkg::CFG_WIDTH-1:0]       i_cfg_data
);
    import bmc_pkg::*;

    logic                   r_in_vld;
    logic                   r_pressed;
    logic [TIME_BITS-1:0]   r_now;
    logic                   r_out_vld;
    t_event                 r_event;
    logic [TALLY_WIDTH-1:0] r_tally;
    logic                   advance;
    logic                   fire;
    logic                   accept;
    t_cfg                   cfg;
    t_event                 step_event;
    logic [TALLY_WIDTH-1:0] step_tally;

    assign advance = !r_out_vld || i_m_tready;
    assign fire = r_in_vld && advance;
    assign o_s_tready = !r_in_vld || advance;
    assign accept = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    bmc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    bmc_step #(
        .QUINT_CLICKS (QUINT_CLICKS),
        .TIME_BITS    (TIME_BITS)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_pressed (r_pressed),
        .i_now     (r_now),
        .i_cfg     (cfg),
        .o_event   (step_event),
        .o_tally   (step_tally)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pressed <= i_s_tdata[0];
            r_now <= i_s_tdata[TIME_BITS:1];
        end
        if (fire) begin
            r_event <= step_event;
            r_tally <= step_tally;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata = {3'b000, r_tally, r_event};

endmodule

`default_nettype wire

// ----- hdl/bmc_checker.sv -----
`default_nettype none

module bmc_checker #(
    parameter int unsigned QUINT_CLICKS = 5
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_s_tready,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata
);
    import bmc_pkg::*;

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

    // reported event always clears the tally
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1:0] != EV_NONE) |-> (o_m_tdata[4:2] == 3'd0))
        else $error("event with pending clicks");

    // tally never stays at the quintuple count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[4:2] < 3'(QUINT_CLICKS) && o_m_tdata[7:5] == 3'd0))
        else $error("pending clicks out of range");

    // input side only stalls behind a stalled result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without output stall");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind button_multi_click_classifier_top bmc_checker #(
    .QUINT_CLICKS (QUINT_CLICKS)
) u_bmc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

// ----- verif/button_multi_click_classifier_top_test.sv -----
`default_nettype none

module button_multi_click_classifier_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bmc_pkg::*;

    localparam int unsigned QUINT_CLICKS = 5;
    localparam int unsigned TIME_BITS = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 200;

    typedef struct packed {
        t_event              ev;
        logic [TALLY_WIDTH-1:0] pending;
    } t_tally_report;

    typedef struct packed {
        logic          pressed;
        logic [31:0]   now_ms;
        logic          typed;
        t_tally_report want;
    } t_stim_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_s_tvalid = 1'b0;
    logic                       o_s_tready;
    logic [39:0]                i_s_tdata = '0;   // pressed, now_ms
    logic                       o_m_tvalid;
    logic                       i_m_tready = 1'b0;
    logic [7:0]                 o_m_tdata;        // event_res, clicks_pending
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [CFG_WIDTH-1:0]       i_cfg_data = '0;

    button_multi_click_classifier_top #(
        .QUINT_CLICKS(QUINT_CLICKS),
        .TIME_BITS(TIME_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // classifier shadow state
    t_cfg                   timing = '{MIN_PRESS_RESET, MAX_PRESS_RESET,
                                       MULTI_WINDOW_RESET, SINGLE_FAST_RESET};
    logic                   btn_held = 1'b0;
    logic [31:0]            press_start_ms = '0;
    logic [31:0]            burst_start_ms = '0;
    logic [TALLY_WIDTH-1:0] click_count = '0;

    t_tally_report expected_reports[$];
    int            mismatches = 0;
    int            stall_cycles = 0;
    int            calm_tx = 0;
    logic [31:0]   sim_ms = '0;

    // default timing: min 50, max 1000, window 10000, fast 1000
    t_stim_row directed_rows [28] = '{
        '{1'b0, 32'd0,     1'b1, '{EV_NONE,   3'd0}},
        '{1'b1, 32'd100,   1'b0, '{EV_NONE,   3'd0}},
        '{1'b1, 32'd120,   1'b0, '{EV_NONE,   3'd0}},
        '{1'b0, 32'd150,   1'b1, '{EV_NONE,   3'd1}},
        '{1'b0, 32'd1101,  1'b1, '{EV_SHORT,  3'd0}},
        '{1'b1, 32'd2000,  1'b0, '{EV_NONE,   3'd0}},
        '{1'b0, 32'd3000,  1'b1, '{EV_NONE,   3'd1}},
        '{1'b1, 32'd3100,  1'b0, '{EV_NONE,   3'd0}},
        '{1'b0, 32'd3200,  1'b0, '{EV_NONE,   3'd0}},
        '{1'b1, 32'd3300,  1'b0, '{EV_NONE,   3'd0}},
        '{1'b0, 32'd3400,  1'b0, '{EV_NONE,   3'd0}},
        '{1'b1, 32'd3500,  1'b0, '{EV_NONE,   3'd0}},
        '{1'b0, 32'd3600,  1'b0, '{EV_NONE,   3'd0}},
        '{1'b1, 32'd3700,  1'b0, '{EV_NONE,   3'd0}},
        '{1'b0, 32'd3800,  1'b1, '{EV_QUINT,  3'd0}},
        '{1'b1, 32'd4000,  1'b0, '{EV_NONE,   3'd0}},
        '{1'b0, 32'd4100,  1'b0, '{EV_NONE,   3'd0}},
        '{1'b1, 32'd4200,  1'b0, '{EV_NONE,   3'd0}},
        '{1'b0, 32'd4300,  1'b0, '{EV_NONE,   3'd0}},
        '{1'b1, 32'd4400,  1'b0, '{EV_NONE,   3'd0}},
        '{1'b0, 32'd4500,  1'b0, '{EV_NONE,   3'd0}},
        '{1'b0, 32'd14000, 1'b0, '{EV_NONE,   3'd0}},
        '{1'b0, 32'd14001, 1'b1, '{EV_TRIPLE, 3'd0}},
        '{1'b1, 32'hFFFF_FFFF, 1'b1, '{EV_NONE, 3'd0}},
        '{1'b0, 32'h0000_004F, 1'b0, '{EV_NONE, 3'd0}},
        '{1'b1, 32'h0000_0100, 1'b0, '{EV_NONE, 3'd0}},
        '{1'b0, 32'h0000_0200, 1'b0, '{EV_NONE, 3'd0}},
        '{1'b0, 32'h0000_3000, 1'b1, '{EV_NONE, 3'd0}}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic t_tally_report classify_sample(input logic pressed,
                                                      input logic [31:0] now_ms);
        logic [31:0]   held_for;
        logic [31:0]   since_burst;
        t_tally_report r;
        r.ev = EV_NONE;
        if (pressed && !btn_held) begin
            btn_held = 1'b1;
            press_start_ms = now_ms;
            if (click_count == '0) burst_start_ms = now_ms;
        end else if (!pressed && btn_held) begin
            held_for = now_ms - press_start_ms;
            btn_held = 1'b0;
            if (held_for >= timing.min_press_ms && held_for <= timing.max_press_ms
                && click_count < TALLY_MAX) begin
                click_count = click_count + 1'b1;
            end
        end
        if (click_count != '0) begin
            since_burst = now_ms - burst_start_ms;
            if (click_count >= QUINT_CLICKS && since_burst <= timing.multi_window_ms) begin
                r.ev = EV_QUINT;
                click_count = '0;
            end else if (since_burst > timing.multi_window_ms) begin
                if (click_count == TALLY_TRIPLE) r.ev = EV_TRIPLE;
                else if (click_count == TALLY_ONE) r.ev = EV_SHORT;
                click_count = '0;
            end else if (click_count == TALLY_ONE && since_burst > timing.single_fast_ms
                         && !btn_held) begin
                r.ev = EV_SHORT;
                click_count = '0;
            end
        end
        r.pending = click_count;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) gap_len = 0;
        else if (r < 88) gap_len = $urandom_range(1, 3);
        else if (r < 97) gap_len = $urandom_range(4, 12);
        else gap_len = $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_press_len();
        int r;
        logic [31:0] lo;
        logic [31:0] hi;
        r = $urandom_range(0, 9);
        lo = {16'd0, timing.min_press_ms};
        hi = {16'd0, timing.max_press_ms};
        if (r < 7 && lo <= hi) pick_press_len = $urandom_range(hi, lo);
        else if (r == 7) pick_press_len = lo + $urandom_range(0, 2) - 1;
        else if (r == 8) pick_press_len = hi + $urandom_range(0, 2) - 1;
        else pick_press_len = $urandom_range(70000, 0);
    endfunction

    task automatic send_sample(input logic pressed, input logic [31:0] now_ms,
                               input logic typed, input t_tally_report typed_report);
        int            gap;
        t_tally_report predicted;
        // occasional hold-off until the pipeline is empty
        if ($urandom_range(0, 149) == 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            while (expected_reports.size() != 0) @(posedge i_clk);
        end
        if (calm_tx > 0) begin
            calm_tx--;
            gap = 0;
        end else begin
            gap = gap_len();
            if ($urandom_range(0, 99) == 0) calm_tx = 40;
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {7'd0, now_ms, pressed};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predicted = classify_sample(pressed, now_ms);
        expected_reports.push_back(typed ? typed_report : predicted);
    endtask

    task automatic drain_requests();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_MIN_PRESS:    timing.min_press_ms = val;
            REG_MAX_PRESS:    timing.max_press_ms = val;
            REG_MULTI_WINDOW: timing.multi_window_ms = val;
            REG_SINGLE_FAST:  timing.single_fast_ms = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [CFG_WIDTH-1:0] min_ms,
                              input logic [CFG_WIDTH-1:0] max_ms,
                              input logic [CFG_WIDTH-1:0] window_ms,
                              input logic [CFG_WIDTH-1:0] fast_ms);
        write_reg(REG_MIN_PRESS, min_ms);
        write_reg(REG_MAX_PRESS, max_ms);
        write_reg(REG_MULTI_WINDOW, window_ms);
        write_reg(REG_SINGLE_FAST, fast_ms);
        // out-of-range index, must leave the timing alone
        write_reg(CFG_INDEX_WIDTH'($urandom_range(255, 4)),
                  CFG_WIDTH'($urandom_range(65535, 0)));
    endtask

    // click bursts with random content, plus noise and idle polls
    task automatic drive_bursts(input int quota);
        int            sent;
        int            clicks;
        int            mode;
        logic [31:0]   press_len;
        logic [31:0]   press_at;
        t_tally_report none_report;
        none_report = '{EV_NONE, 3'd0};
        sent = 0;
        while (sent < quota) begin
            mode = $urandom_range(0, 9);
            if (mode < 8) begin
                clicks = $urandom_range(1, 6);
                for (int c = 0; c < clicks; c++) begin
                    press_len = pick_press_len();
                    sim_ms += $urandom_range(timing.multi_window_ms / 6 + 1, 0);
                    press_at = sim_ms;
                    send_sample(1'b1, press_at, 1'b0, none_report);
                    if ($urandom_range(0, 3) == 0) begin
                        send_sample(1'b1, press_at + press_len / 2, 1'b0, none_report);
                        sent++;
                    end
                    sim_ms = press_at + press_len;
                    send_sample(1'b0, sim_ms, 1'b0, none_report);
                    sent += 2;
                end
                case ($urandom_range(0, 3))
                    0: sim_ms += timing.single_fast_ms + $urandom_range(0, 2);
                    1: sim_ms += timing.multi_window_ms + $urandom_range(0, 2);
                    2: sim_ms += $urandom_range(timing.multi_window_ms, 0);
                    default: sim_ms += $urandom_range(70000, 0);
                endcase
                send_sample(1'b0, sim_ms, 1'b0, none_report);
                sent++;
            end else if (mode == 8) begin
                sim_ms = $urandom;
                send_sample(1'($urandom_range(0, 1)), sim_ms, 1'b0, none_report);
                sent++;
            end else begin
                sim_ms += $urandom_range(0, 50);
                send_sample(1'($urandom_range(0, 1)), sim_ms, 1'b0, none_report);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        int                   lo;
        int                   hi;
        int                   win;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_sample(directed_rows[i].pressed, directed_rows[i].now_ms,
                        directed_rows[i].typed, directed_rows[i].want);
        sim_ms = 32'h0000_4000;

        for (int p = 0; p < 6; p++) begin
            drain_requests();
            case (p)
                1: set_timing(16'd0, 16'd0, 16'd0, 16'd0);
                2: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: begin
                    // min above max, no press counts
                    lo = $urandom_range(2000, 300);
                    set_timing(CFG_WIDTH'(lo), CFG_WIDTH'($urandom_range(lo - 1, 0)),
                               16'd5000, 16'd800);
                end
                5: set_timing(MIN_PRESS_RESET, MAX_PRESS_RESET, MULTI_WINDOW_RESET,
                              SINGLE_FAST_RESET);
                default: begin
                    lo = $urandom_range(40, 0);
                    hi = lo + $urandom_range(300, 0);
                    win = $urandom_range(4000, 100);
                    set_timing(CFG_WIDTH'(lo), CFG_WIDTH'(hi), CFG_WIDTH'(win),
                               CFG_WIDTH'($urandom_range(win, 0)));
                end
            endcase
            drive_bursts(PHASE_ITEMS);
        end

        drain_requests();
        repeat (10) @(posedge i_clk);
        if (expected_reports.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : result_sink
        int rx_stall;
        int rx_calm;
        rx_stall = 0;
        rx_calm = 0;
        forever begin
            @(negedge i_clk);
            if (rx_calm > 0) begin
                rx_calm--;
                i_m_tready <= 1'b1;
            end else if (rx_stall > 0) begin
                rx_stall--;
                i_m_tready <= 1'b0;
            end else begin
                rx_stall = gap_len();
                if ($urandom_range(0, 99) == 0) rx_calm = 50;
                i_m_tready <= (rx_stall == 0);
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        t_tally_report want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_m_tdata));
            end else begin
                want = expected_reports.pop_front();
                if (o_m_tdata[1:0] !== want.ev)
                    report_mismatch($sformatf("event_res %0d, want %0d",
                                              o_m_tdata[1:0], want.ev));
                if (o_m_tdata[4:2] !== want.pending)
                    report_mismatch($sformatf("clicks_pending %0d, want %0d",
                                              o_m_tdata[4:2], want.pending));
                if (o_m_tdata[7:5] !== 3'd0)
                    report_mismatch($sformatf("padding bits %b", o_m_tdata[7:5]));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/bmc_pkg.sv
hdl/bmc_cfg.sv
hdl/bmc_step.sv
hdl/button_multi_click_classifier_top.sv
hdl/bmc_checker.sv
verif/button_multi_click_classifier_top_test.sv
